>>> rtl/pressure_door_open_detector_assert.svh
// Assertion macros shared by the pressure door-open detector RTL.
// Each macro expects clk and rst_n to be visible in the using module.
`ifndef PRESSURE_DOOR_OPEN_DETECTOR_ASSERT_SVH
`define PRESSURE_DOOR_OPEN_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDOD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdod assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PDOD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdod assertion failed");

`endif

>>> rtl/pdod_pkg.sv
// Package for the pressure door-open detector: sizes, register codes and payload types.
// Used by pdod_core and pressure_door_open_detector; depends on nothing.
package pdod_pkg;

  localparam int WINDOW    = 16;
  localparam int WIN_W     = $clog2(WINDOW);
  localparam int P_W       = 21;
  localparam int SUM_W     = P_W + $clog2(WINDOW);
  localparam int DIFF_W    = P_W + 2;
  localparam int STRIKE_W  = $clog2(WINDOW + 1);
  localparam int CNT_OUT_W = 5;
  localparam int SLOT_W    = 4;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] OPEN_THRESHOLD_RST = 12'd368;
  localparam logic [CFG_W-1:0] BAND_BELOW_RST     = 12'd128;
  localparam logic [CFG_W-1:0] BAND_ABOVE_RST     = 12'd160;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_PRELOAD = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_THRESHOLD,
    CFG_BAND_BELOW,
    CFG_BAND_ABOVE
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] open_threshold;
    logic [CFG_W-1:0] band_below;
    logic [CFG_W-1:0] band_above;
  } cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [P_W-1:0]    pressure;
    logic [SLOT_W-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic                 door_open;
    logic [P_W-1:0]       closed_average;
    logic [P_W-1:0]       open_mean;
    logic [CNT_OUT_W-1:0] strike_count;
  } out_item_t;

endpackage

>>> rtl/pdod_core.sv
// Detector state and its combinational update: sample window, running sum, averages, strikes.
// Depends on pdod_pkg and pressure_door_open_detector_assert.svh.
`include "pressure_door_open_detector_assert.svh"

module pdod_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  pdod_pkg::in_item_t  item,
  input  pdod_pkg::cfg_t      cfg,
  output pdod_pkg::out_item_t result
);
  import pdod_pkg::*;

  logic [P_W-1:0]      window_r [WINDOW];
  logic [P_W-1:0]      window_nxt [WINDOW];
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [P_W-1:0]      closed_avg_r, closed_avg_nxt;
  logic [P_W-1:0]      open_avg_r, open_avg_nxt;
  logic [STRIKE_W-1:0] strikes_r, strikes_nxt;
  logic                open_flag_r, open_flag_nxt;

  logic [P_W-1:0]           p;
  logic [WIN_W-1:0]         slot_idx;
  logic                     slot_ok;
  logic [SUM_W-1:0]         sum_shift;
  logic [P_W-1:0]           mean;
  logic signed [DIFF_W-1:0] th_s, bb_s, ba_s;
  logic signed [DIFF_W-1:0] closed_d, open_d, closed_d2, open_d2;
  logic                     settled, do_closed, do_open, push, strike;
  logic [P_W-1:0]           closed_upd, open_upd;

  assign p        = item.pressure;
  assign slot_idx = WIN_W'(item.slot_index);
  assign slot_ok  = (32'(item.slot_index) < 32'(WINDOW));

  assign th_s = $signed({{(DIFF_W-CFG_W){1'b0}}, cfg.open_threshold});
  assign bb_s = $signed({{(DIFF_W-CFG_W){1'b0}}, cfg.band_below});
  assign ba_s = $signed({{(DIFF_W-CFG_W){1'b0}}, cfg.band_above});

  assign closed_d = $signed({2'b00, closed_avg_r}) - $signed({2'b00, p});
  assign open_d   = $signed({2'b00, open_avg_r}) - $signed({2'b00, p});

  assign sum_shift = sum_r - SUM_W'(window_r[0]) + SUM_W'(p);
  assign mean      = P_W'(sum_shift / WINDOW);

  assign settled   = open_flag_r ? (strikes_r == STRIKE_W'(WINDOW)) : (strikes_r == '0);
  assign do_closed = settled && ((closed_avg_r == '0) ||
                     ((closed_d > -bb_s) && (closed_d < ba_s) && !open_flag_r));
  assign do_open   = settled && !do_closed && open_flag_r &&
                     ((open_avg_r == '0) || ((open_d > -ba_s) && (open_d < bb_s)));
  assign push      = do_closed || do_open;

  assign closed_upd = do_closed ? mean : closed_avg_r;
  assign open_upd   = do_open ? mean : open_avg_r;

  assign closed_d2 = $signed({2'b00, closed_upd}) - $signed({2'b00, p});
  assign open_d2   = $signed({2'b00, open_upd}) - $signed({2'b00, p});
  assign strike    = (closed_d2 < -th_s) || ((open_upd != '0) && (open_d2 < th_s));

  always_comb begin
    window_nxt     = window_r;
    sum_nxt        = sum_r;
    closed_avg_nxt = closed_avg_r;
    open_avg_nxt   = open_avg_r;
    strikes_nxt    = strikes_r;
    open_flag_nxt  = open_flag_r;
    if (step) begin
      if (item.req_type == REQ_PRELOAD) begin
        if (slot_ok) begin
          window_nxt[slot_idx] = p;
          sum_nxt = sum_r - SUM_W'(window_r[slot_idx]) + SUM_W'(p);
        end
      end else begin
        closed_avg_nxt = closed_upd;
        open_avg_nxt   = open_upd;
        if (strike) begin
          if (strikes_r > STRIKE_W'(WINDOW - 1)) begin
            open_flag_nxt = 1'b1;
          end else begin
            strikes_nxt = strikes_r + 1'b1;
          end
        end else begin
          if (strikes_r == '0) begin
            open_flag_nxt = 1'b0;
            open_avg_nxt  = '0;
          end else begin
            strikes_nxt = strikes_r - 1'b1;
          end
        end
        if (open_flag_nxt != open_flag_r) begin
          for (int i = 0; i < WINDOW; i++) begin
            window_nxt[i] = p;
          end
          sum_nxt = SUM_W'(p) * SUM_W'(WINDOW);
        end else if (push) begin
          for (int i = 0; i < WINDOW - 1; i++) begin
            window_nxt[i] = window_r[i+1];
          end
          window_nxt[WINDOW-1] = p;
          sum_nxt = sum_shift;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        window_r[i] <= '0;
      end
      sum_r        <= '0;
      closed_avg_r <= '0;
      open_avg_r   <= '0;
      strikes_r    <= '0;
      open_flag_r  <= 1'b0;
    end else begin
      window_r     <= window_nxt;
      sum_r        <= sum_nxt;
      closed_avg_r <= closed_avg_nxt;
      open_avg_r   <= open_avg_nxt;
      strikes_r    <= strikes_nxt;
      open_flag_r  <= open_flag_nxt;
    end
  end

  assign result.door_open      = open_flag_nxt;
  assign result.closed_average = closed_avg_nxt;
  assign result.open_mean      = open_avg_nxt;
  assign result.strike_count   = CNT_OUT_W'(strikes_nxt);

  `PDOD_ASSERT_NOW(a_strikes_bounded, 1'b1, strikes_r <= STRIKE_W'(WINDOW))
  `PDOD_ASSERT_NOW(a_open_avg_needs_flag, open_avg_r != '0, open_flag_r)
  `PDOD_ASSERT_NOW(a_flag_rises_at_full, $rose(open_flag_r), strikes_r == STRIKE_W'(WINDOW))

endmodule

>>> rtl/pressure_door_open_detector.sv
// Top level of the pressure door-open detector: request buffer, result register, config registers.
// Depends on pdod_pkg, pdod_core and pressure_door_open_detector_assert.svh.
//
//   port group  | direction | handshake          | payload
//   in_         | input     | in_valid/in_ready  | in_item (pdod_pkg::in_item_t)
//   out_        | output    | out_valid/out_ready| out_item (pdod_pkg::out_item_t)
//   cfg_        | input     | cfg_we             | cfg_index, cfg_wdata
//
// One request per cycle is sustained while out_ready stays high; an accepted request is held in
// the request buffer, and its result is registered in the result register and presented from there.
// The state update for a request is combinational logic in pdod_core, kept fast by a running sum.
// A one-entry request buffer lets a request be taken while the result register waits.
// Reset is synchronous; it clears the window, averages, strikes, flag and valid bits, and loads the config defaults.
`include "pressure_door_open_detector_assert.svh"

module pressure_door_open_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pdod_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pdod_pkg::out_item_t                out_item,
  input  logic                               cfg_we,
  input  logic [pdod_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdod_pkg::CFG_W-1:0]         cfg_wdata
);
  import pdod_pkg::*;

  cfg_t      cfg_r;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      out_valid_r;
  logic      advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_threshold <= OPEN_THRESHOLD_RST;
      cfg_r.band_below     <= BAND_BELOW_RST;
      cfg_r.band_above     <= BAND_ABOVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OPEN_THRESHOLD: cfg_r.open_threshold <= cfg_wdata;
        CFG_BAND_BELOW:     cfg_r.band_below     <= cfg_wdata;
        CFG_BAND_ABOVE:     cfg_r.band_above     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= (in_valid && in_ready) || (in_valid_r && !advance);
      out_valid_r <= advance || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  pdod_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `PDOD_ASSERT_NEXT(a_buffer_holds, in_valid_r && !advance, in_valid_r && $stable(in_item_r))
  `PDOD_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_r)

endmodule
